[hdl/segment_box_face_intercept_defines.svh]
// Assertion macros used by the checker file.
`ifndef SEGMENT_BOX_FACE_INTERCEPT_DEFINES_SVH
`define SEGMENT_BOX_FACE_INTERCEPT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define SBFI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define SBFI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/sbfi_pkg.sv]
`default_nettype none
package sbfi_pkg;

  localparam int NUM_AXES   = 3;
  localparam int NUM_PLANES = 6;
  localparam int MAG_W      = 33;
  localparam int PROD_W     = 2 * MAG_W;
  localparam int DIV_STEPS  = MAG_W;
  localparam int ROOT_W     = 35;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 3;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIST_W     = 33;

  // d*d below the Q32.32 threshold exactly when |d| is at most this
  localparam logic [MAG_W-1:0] PAR_DM_MAX = MAG_W'(20);

  typedef logic signed [31:0]  q16_t;
  typedef logic [MAG_W-1:0]    mag_t;
  typedef logic [PROD_W-1:0]   prod_t;
  typedef logic [ROOT_W-1:0]   root_t;

  typedef enum logic [2:0] {
    FACE_NEG_X,
    FACE_POS_X,
    FACE_NEG_Y,
    FACE_POS_Y,
    FACE_NEG_Z,
    FACE_POS_Z
  } face_t;

  typedef struct packed {
    q16_t box_min_x;
    q16_t box_max_x;
    q16_t box_min_y;
    q16_t box_max_y;
    q16_t box_min_z;
    q16_t box_max_z;
    q16_t start_x;
    q16_t start_y;
    q16_t start_z;
    q16_t end_x;
    q16_t end_y;
    q16_t end_z;
  } in_t;

  // Divider phase: remainder/quotient word per plane and other axis
  typedef struct packed {
    logic                 valid;
    q16_t [2:0]           s;
    q16_t [2:0]           lo;
    q16_t [2:0]           hi;
    mag_t [2:0]           dmag;
    logic [5:0]           pok;
    mag_t [5:0]           nm;
    logic [5:0][1:0]      neg;
    prod_t [5:0][1:0]     rq;
  } div_t;

  typedef struct packed {
    logic                 valid;
    logic [5:0]           ok;
    q16_t [5:0][2:0]      p;
    mag_t [5:0][2:0]      off;
  } pt_t;

  typedef struct packed {
    logic                 valid;
    logic [5:0]           ok;
    q16_t [5:0][2:0]      p;
    prod_t [5:0][2:0]     sq;
  } sqm_t;

  typedef struct packed {
    logic [RAD_W-1:0]     rad;
    logic [REM_W-1:0]     rem;
    root_t                root;
  } sqs_t;

  typedef struct packed {
    logic                 valid;
    logic [5:0]           ok;
    q16_t [5:0][2:0]      p;
    sqs_t [5:0]           st;
  } sq_t;

  typedef struct packed {
    logic                 ok;
    face_t                face;
    q16_t [2:0]           p;
    root_t                len;
  } best_t;

  // Axis index of the j-th axis other than ax
  function automatic int other_axis(input int ax, input int j);
    if (j == 0) return (ax == 0) ? 1 : 0;
    return (ax == 2) ? 1 : 2;
  endfunction

  // One restoring division step: shift in one numerator bit, try subtract
  function automatic prod_t div_step(input prod_t rq, input mag_t dv);
    logic [MAG_W:0] top;
    logic           qb;
    top = rq[PROD_W-1:MAG_W-1];
    qb  = (top >= {1'b0, dv});
    if (qb) top = top - {1'b0, dv};
    return {top[MAG_W-1:0], rq[MAG_W-2:0], qb};
  endfunction

  // One digit of a floor square root
  function automatic sqs_t sqrt_step(input sqs_t x);
    logic [REM_W-1:0] t;
    logic [REM_W-1:0] trial;
    sqs_t             y;
    t     = {x.rem[REM_W-3:0], x.rad[RAD_W-1 -: 2]};
    trial = {1'b0, x.root, 2'b01};
    if (t >= trial) begin
      y.rem  = t - trial;
      y.root = {x.root[ROOT_W-2:0], 1'b1};
    end else begin
      y.rem  = t;
      y.root = {x.root[ROOT_W-2:0], 1'b0};
    end
    y.rad = {x.rad[RAD_W-3:0], 2'b00};
    return y;
  endfunction

  // Keep a unless b is valid and either a is not or b is strictly nearer; a is the earlier plane
  function automatic best_t pick_best(input best_t a, input best_t b);
    if (b.ok && (!a.ok || (b.len < a.len))) return b;
    return a;
  endfunction

endpackage
`default_nettype wire

[hdl/sbfi_intf.sv]
`default_nettype none
interface sbfi_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] box_min_x;
  logic signed [31:0] box_max_x;
  logic signed [31:0] box_min_y;
  logic signed [31:0] box_max_y;
  logic signed [31:0] box_min_z;
  logic signed [31:0] box_max_z;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_z;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic signed [31:0] end_z;

  modport source (
    output valid, box_min_x, box_max_x, box_min_y, box_max_y, box_min_z, box_max_z,
    output start_x, start_y, start_z, end_x, end_y, end_z,
    input  ready
  );
  modport sink (
    input  valid, box_min_x, box_max_x, box_min_y, box_max_y, box_min_z, box_max_z,
    input  start_x, start_y, start_z, end_x, end_y, end_z,
    output ready
  );
endinterface

interface sbfi_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic [2:0]         face;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic [32:0]        distance;

  modport source (
    output valid, hit, face, point_x, point_y, point_z, distance,
    input  ready
  );
  modport sink (
    input  valid, hit, face, point_x, point_y, point_z, distance,
    output ready
  );
endinterface
`default_nettype wire

[hdl/segment_box_face_intercept.sv]
// Throughput: one item per cycle; 33 restoring divider stages and 35 square
// root stages each retire one bit per cycle, so every stage takes a new item.
// The whole pipeline holds while a result waits unread.
// Reset (rst_n low, synchronous) clears every valid bit; data regs keep state.
`default_nettype none
module segment_box_face_intercept (
  input  wire logic       clk,
  input  wire logic       rst_n,
  sbfi_in_if.sink         in_ch,
  sbfi_out_if.source      out_ch
);

  localparam int DS = sbfi_pkg::DIV_STEPS;
  localparam int SS = sbfi_pkg::SQRT_STEPS;

  logic adv;

  logic                 in_valid_r;
  sbfi_pkg::in_t        in_r;
  sbfi_pkg::div_t       b_r, b_nxt;
  sbfi_pkg::div_t       div_r [DS+1];
  sbfi_pkg::div_t       c_nxt;
  sbfi_pkg::pt_t        pt_r, pt_nxt;
  sbfi_pkg::sqm_t       sqm_r, sqm_nxt;
  sbfi_pkg::sq_t        sq_r [SS+1];
  sbfi_pkg::sq_t        sum_nxt;
  logic                 t1_valid_r;
  sbfi_pkg::best_t      t1_r [3];
  sbfi_pkg::best_t      t1_nxt [3];
  logic                 t2_valid_r;
  sbfi_pkg::best_t      t2_r [2];
  sbfi_pkg::best_t      fin;
  logic                 out_valid_r;
  logic                 out_hit_r;
  sbfi_pkg::face_t      out_face_r;
  sbfi_pkg::q16_t [2:0] out_point_r;
  logic [sbfi_pkg::DIST_W-1:0] out_dist_r;

  // Advance every stage while the output register is free or being read
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // Capture the input item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (adv) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_r.box_min_x <= in_ch.box_min_x;
      in_r.box_max_x <= in_ch.box_max_x;
      in_r.box_min_y <= in_ch.box_min_y;
      in_r.box_max_y <= in_ch.box_max_y;
      in_r.box_min_z <= in_ch.box_min_z;
      in_r.box_max_z <= in_ch.box_max_z;
      in_r.start_x   <= in_ch.start_x;
      in_r.start_y   <= in_ch.start_y;
      in_r.start_z   <= in_ch.start_z;
      in_r.end_x     <= in_ch.end_x;
      in_r.end_y     <= in_ch.end_y;
      in_r.end_z     <= in_ch.end_z;
    end
  end

  // Deltas, plane offsets, parallel and range tests
  always_comb begin
    sbfi_pkg::q16_t     en [3];
    logic signed [32:0] dv;
    logic signed [32:0] nv;
    logic [2:0]         dneg;
    logic               nneg;
    sbfi_pkg::q16_t     pl;
    int                 ax;
    int                 o;
    b_nxt       = '0;
    b_nxt.valid = in_valid_r;
    b_nxt.s[0]  = in_r.start_x;
    b_nxt.s[1]  = in_r.start_y;
    b_nxt.s[2]  = in_r.start_z;
    b_nxt.lo[0] = in_r.box_min_x;
    b_nxt.lo[1] = in_r.box_min_y;
    b_nxt.lo[2] = in_r.box_min_z;
    b_nxt.hi[0] = in_r.box_max_x;
    b_nxt.hi[1] = in_r.box_max_y;
    b_nxt.hi[2] = in_r.box_max_z;
    en[0] = in_r.end_x;
    en[1] = in_r.end_y;
    en[2] = in_r.end_z;
    dneg  = '0;
    for (int k = 0; k < sbfi_pkg::NUM_AXES; k++) begin
      dv = {en[k][31], en[k]} - {b_nxt.s[k][31], b_nxt.s[k]};
      dneg[k] = dv[32];
      b_nxt.dmag[k] = dv[32] ? sbfi_pkg::MAG_W'(-dv) : sbfi_pkg::MAG_W'(dv);
    end
    for (int i = 0; i < sbfi_pkg::NUM_PLANES; i++) begin
      ax = i >> 1;
      pl = (i % 2 == 1) ? b_nxt.hi[ax] : b_nxt.lo[ax];
      nv = {pl[31], pl} - {b_nxt.s[ax][31], b_nxt.s[ax]};
      nneg = nv[32];
      b_nxt.nm[i] = nneg ? sbfi_pkg::MAG_W'(-nv) : sbfi_pkg::MAG_W'(nv);
      b_nxt.pok[i] = (b_nxt.dmag[ax] > sbfi_pkg::PAR_DM_MAX)
                   && ((nv == '0) || (nneg == dneg[ax]))
                   && (b_nxt.nm[i] <= b_nxt.dmag[ax]);
      for (int j = 0; j < 2; j++) begin
        o = sbfi_pkg::other_axis(ax, j);
        b_nxt.neg[i][j] = dneg[o] ^ nneg ^ dneg[ax];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r.valid <= 1'b0;
    end else if (adv) begin
      b_r <= b_nxt;
    end
  end

  // Form numerators |d_other| * |n|
  always_comb begin
    int o;
    c_nxt = b_r;
    for (int i = 0; i < sbfi_pkg::NUM_PLANES; i++) begin
      for (int j = 0; j < 2; j++) begin
        o = sbfi_pkg::other_axis(i >> 1, j);
        c_nxt.rq[i][j] = sbfi_pkg::prod_t'(b_r.dmag[o]) * sbfi_pkg::prod_t'(b_r.nm[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r[0].valid <= 1'b0;
    end else if (adv) begin
      div_r[0] <= c_nxt;
    end
  end

  // Divider stages: one quotient bit per stage, divisor |d| of the plane axis
  for (genvar g = 0; g < DS; g++) begin : g_div
    sbfi_pkg::div_t div_nxt;

    always_comb begin
      div_nxt = div_r[g];
      for (int i = 0; i < sbfi_pkg::NUM_PLANES; i++) begin
        for (int j = 0; j < 2; j++) begin
          div_nxt.rq[i][j] = sbfi_pkg::div_step(div_r[g].rq[i][j], div_r[g].dmag[i >> 1]);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_r[g+1].valid <= 1'b0;
      end else if (adv) begin
        div_r[g+1] <= div_nxt;
      end
    end
  end

  // Round the quotients, place the crossing point and test it against the face
  always_comb begin
    sbfi_pkg::mag_t     rem;
    sbfi_pkg::mag_t     qv;
    sbfi_pkg::mag_t     dvs;
    logic               rnd;
    logic [33:0]        m;
    logic signed [33:0] sv;
    logic signed [33:0] pk;
    logic signed [33:0] lo34;
    logic signed [33:0] hi34;
    int                 ax;
    int                 o;
    pt_nxt       = '0;
    pt_nxt.valid = div_r[DS].valid;
    for (int i = 0; i < sbfi_pkg::NUM_PLANES; i++) begin
      ax = i >> 1;
      pt_nxt.ok[i] = div_r[DS].pok[i];
      pt_nxt.p[i][ax] = (i % 2 == 1) ? div_r[DS].hi[ax] : div_r[DS].lo[ax];
      pt_nxt.off[i][ax] = div_r[DS].nm[i];
      dvs = div_r[DS].dmag[ax];
      for (int j = 0; j < 2; j++) begin
        o    = sbfi_pkg::other_axis(ax, j);
        rem  = div_r[DS].rq[i][j][sbfi_pkg::PROD_W-1:sbfi_pkg::MAG_W];
        qv   = div_r[DS].rq[i][j][sbfi_pkg::MAG_W-1:0];
        rnd  = ({rem, 1'b0} >= {1'b0, dvs});
        m    = {1'b0, qv} + {33'd0, rnd};
        sv   = {{2{div_r[DS].s[o][31]}}, div_r[DS].s[o]};
        lo34 = {{2{div_r[DS].lo[o][31]}}, div_r[DS].lo[o]};
        hi34 = {{2{div_r[DS].hi[o][31]}}, div_r[DS].hi[o]};
        pk   = div_r[DS].neg[i][j] ? (sv - $signed(m)) : (sv + $signed(m));
        if ((pk < lo34) || (pk > hi34)) pt_nxt.ok[i] = 1'b0;
        pt_nxt.p[i][o]   = pk[31:0];
        pt_nxt.off[i][o] = m[sbfi_pkg::MAG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_r.valid <= 1'b0;
    end else if (adv) begin
      pt_r <= pt_nxt;
    end
  end

  // Square the offsets
  always_comb begin
    sqm_nxt       = '0;
    sqm_nxt.valid = pt_r.valid;
    sqm_nxt.ok    = pt_r.ok;
    sqm_nxt.p     = pt_r.p;
    for (int i = 0; i < sbfi_pkg::NUM_PLANES; i++) begin
      for (int k = 0; k < sbfi_pkg::NUM_AXES; k++) begin
        sqm_nxt.sq[i][k] = sbfi_pkg::prod_t'(pt_r.off[i][k])
                         * sbfi_pkg::prod_t'(pt_r.off[i][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqm_r.valid <= 1'b0;
    end else if (adv) begin
      sqm_r <= sqm_nxt;
    end
  end

  // Sum the squares into the root radicand
  always_comb begin
    sum_nxt       = '0;
    sum_nxt.valid = sqm_r.valid;
    sum_nxt.ok    = sqm_r.ok;
    sum_nxt.p     = sqm_r.p;
    for (int i = 0; i < sbfi_pkg::NUM_PLANES; i++) begin
      sum_nxt.st[i].rad = sbfi_pkg::RAD_W'(sqm_r.sq[i][0])
                        + sbfi_pkg::RAD_W'(sqm_r.sq[i][1])
                        + sbfi_pkg::RAD_W'(sqm_r.sq[i][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r[0].valid <= 1'b0;
    end else if (adv) begin
      sq_r[0] <= sum_nxt;
    end
  end

  // Square root stages: one root bit per stage
  for (genvar g = 0; g < SS; g++) begin : g_sqrt
    sbfi_pkg::sq_t sq_nxt;

    always_comb begin
      sq_nxt = sq_r[g];
      for (int i = 0; i < sbfi_pkg::NUM_PLANES; i++) begin
        sq_nxt.st[i] = sbfi_pkg::sqrt_step(sq_r[g].st[i]);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_r[g+1].valid <= 1'b0;
      end else if (adv) begin
        sq_r[g+1] <= sq_nxt;
      end
    end
  end

  // First level of the nearest-crossing tree: pairs of planes
  always_comb begin
    sbfi_pkg::best_t ca;
    sbfi_pkg::best_t cb;
    for (int k = 0; k < 3; k++) begin
      ca.ok   = sq_r[SS].ok[2*k];
      ca.face = sbfi_pkg::face_t'(2*k);
      ca.p    = sq_r[SS].p[2*k];
      ca.len  = sq_r[SS].st[2*k].root;
      cb.ok   = sq_r[SS].ok[2*k+1];
      cb.face = sbfi_pkg::face_t'(2*k+1);
      cb.p    = sq_r[SS].p[2*k+1];
      cb.len  = sq_r[SS].st[2*k+1].root;
      t1_nxt[k] = sbfi_pkg::pick_best(ca, cb);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_valid_r <= 1'b0;
    end else if (adv) begin
      t1_valid_r <= sq_r[SS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_r <= t1_nxt;
    end
  end

  // Second level: x pair against y pair, z pair carried along
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t2_valid_r <= 1'b0;
    end else if (adv) begin
      t2_valid_r <= t1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t2_r[0] <= sbfi_pkg::pick_best(t1_r[0], t1_r[1]);
      t2_r[1] <= t1_r[2];
    end
  end

  // Final pick; zero the fields on a miss and saturate the distance
  assign fin = sbfi_pkg::pick_best(t2_r[0], t2_r[1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= t2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit_r   <= fin.ok;
      out_face_r  <= fin.ok ? fin.face : sbfi_pkg::FACE_NEG_X;
      out_point_r <= fin.ok ? fin.p : '0;
      if (!fin.ok) begin
        out_dist_r <= '0;
      end else if (|fin.len[sbfi_pkg::ROOT_W-1:sbfi_pkg::DIST_W]) begin
        out_dist_r <= '1;
      end else begin
        out_dist_r <= fin.len[sbfi_pkg::DIST_W-1:0];
      end
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.hit      = out_hit_r;
  assign out_ch.face     = out_face_r;
  assign out_ch.point_x  = out_point_r[0];
  assign out_ch.point_y  = out_point_r[1];
  assign out_ch.point_z  = out_point_r[2];
  assign out_ch.distance = out_dist_r;

endmodule
`default_nettype wire

[hdl/sbfi_checker.sv]
`default_nettype none
`include "segment_box_face_intercept_defines.svh"
module sbfi_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               out_hit,
  input wire logic [2:0]         out_face,
  input wire logic signed [31:0] out_point_x,
  input wire logic signed [31:0] out_point_y,
  input wire logic signed [31:0] out_point_z,
  input wire logic [32:0]        out_distance
);

  logic [132:0] out_payload;
  logic         in_seen;
  logic         stalled;
  logic         fields_zero;

  assign out_payload = {out_hit, out_face, out_point_x, out_point_y, out_point_z,
                        out_distance};
  assign in_seen     = in_valid || !in_valid;
  assign stalled     = out_valid && !out_ready;
  assign fields_zero = (out_face == sbfi_pkg::FACE_NEG_X) && (out_distance == 33'd0)
                    && (out_point_x == 32'sd0) && (out_point_y == 32'sd0)
                    && (out_point_z == 32'sd0);

  // A waiting item stays and holds its payload
  `SBFI_ASSERT_NEXT(a_out_hold, stalled, out_valid, "result dropped while stalled")
  `SBFI_ASSERT_NEXT(a_out_stable, stalled, $stable(out_payload), "stalled result changed")

  // Input only backs off while a result waits unread
  `SBFI_ASSERT_NOW(a_ready_stall, in_seen && !in_ready, stalled, "input stalled without cause")

  // A miss carries all-zero fields
  `SBFI_ASSERT_NOW(a_miss_zero, out_valid && !out_hit, fields_zero, "miss with non-zero fields")

  // A hit names one of the six faces
  `SBFI_ASSERT_NOW(a_hit_face, out_valid && out_hit, out_face <= sbfi_pkg::FACE_POS_Z, "bad face")

endmodule

bind segment_box_face_intercept sbfi_checker u_sbfi_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_hit      (out_ch.hit),
  .out_face     (out_ch.face),
  .out_point_x  (out_ch.point_x),
  .out_point_y  (out_ch.point_y),
  .out_point_z  (out_ch.point_z),
  .out_distance (out_ch.distance)
);
`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps
module tb;

  localparam int ONE          = 32'h0001_0000;
  localparam int HALF         = 32'h0000_8000;
  localparam int RANDOM_ITEMS = 1400;
  localparam int HOLD_AT      = 200;
  localparam int HOLD_CYCLES  = 500;
  localparam int DRAIN_CYCLES = 150;
  localparam int CYCLE_LIMIT  = 200000;
  localparam logic [127:0] DIST_SAT = 128'h1_FFFF_FFFF;
  localparam logic [127:0] PAR_LIMIT = 128'd430;

  typedef struct packed {
    logic              hit;
    sbfi_pkg::face_t   face;
    sbfi_pkg::q16_t    px;
    sbfi_pkg::q16_t    py;
    sbfi_pkg::q16_t    pz;
    logic [32:0]       len;
  } hit_t;

  typedef struct {
    sbfi_pkg::in_t seg;
    bit            typed;
    hit_t          want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  sbfi_in_if  in_ch ();
  sbfi_out_if out_ch ();

  segment_box_face_intercept DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  hit_t   pending_hits[$];
  row_t   rows[$];
  int     errors = 0;
  int     results_seen = 0;
  int     cycles = 0;
  bit     row_typed;
  hit_t   row_want;
  int     burst_left;
  logic [7:0] stall_pat = 8'hFF;
  logic [7:0] phase = 8'd0;
  int     hold_left = 0;
  bit     held = 1'b0;

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Nearest face crossing of a segment against a box, exact integer arithmetic
  function automatic hit_t intercept_predict(input sbfi_pkg::in_t x);
    longint lo[3], hi[3], s[3], d[3], p[3];
    longint plane, n, nm, dm, m;
    logic [127:0] num, q, rem, sum, root, c, off;
    hit_t best;
    logic [127:0] best_dist;
    bit found, ok, neg;
    int ax;
    lo[0] = x.box_min_x; hi[0] = x.box_max_x;
    lo[1] = x.box_min_y; hi[1] = x.box_max_y;
    lo[2] = x.box_min_z; hi[2] = x.box_max_z;
    s[0] = x.start_x; s[1] = x.start_y; s[2] = x.start_z;
    d[0] = longint'(x.end_x) - s[0];
    d[1] = longint'(x.end_y) - s[1];
    d[2] = longint'(x.end_z) - s[2];
    best = '0;
    best_dist = '0;
    found = 1'b0;
    for (int i = 0; i < sbfi_pkg::NUM_PLANES; i++) begin
      ax = i >> 1;
      plane = (i & 1) ? hi[ax] : lo[ax];
      dm = (d[ax] < 0) ? -d[ax] : d[ax];
      // drop near-parallel planes and crossings outside the segment
      if (128'(dm) * 128'(dm) < PAR_LIMIT) continue;
      n = plane - s[ax];
      nm = (n < 0) ? -n : n;
      if (n != 0 && ((n < 0) != (d[ax] < 0))) continue;
      if (nm > dm) continue;
      ok = 1'b1;
      for (int k = 0; k < sbfi_pkg::NUM_AXES; k++) begin
        if (k == ax) begin
          p[k] = plane;
        end else begin
          num = 128'((d[k] < 0) ? -d[k] : d[k]) * 128'(nm);
          q = num / 128'(dm);
          rem = num % 128'(dm);
          if (rem >= 128'(dm) - rem) q = q + 1;
          m = longint'(q);
          neg = ((d[k] < 0) != (n < 0)) != (d[ax] < 0);
          p[k] = s[k] + (neg ? -m : m);
          if (p[k] < lo[k] || p[k] > hi[k]) ok = 1'b0;
        end
      end
      if (!ok) continue;
      sum = '0;
      for (int k = 0; k < sbfi_pkg::NUM_AXES; k++) begin
        off = 128'((p[k] < s[k]) ? s[k] - p[k] : p[k] - s[k]);
        sum = sum + off * off;
      end
      root = '0;
      for (int b = 34; b >= 0; b--) begin
        c = root | (128'd1 << b);
        if (c * c <= sum) root = c;
      end
      // strict less-than keeps the earlier plane on a tie
      if (!found || root < best_dist) begin
        found = 1'b1;
        best_dist = root;
        best.hit = 1'b1;
        best.face = sbfi_pkg::face_t'(i);
        best.px = sbfi_pkg::q16_t'(p[0]);
        best.py = sbfi_pkg::q16_t'(p[1]);
        best.pz = sbfi_pkg::q16_t'(p[2]);
        best.len = (root > DIST_SAT) ? 33'(DIST_SAT) : 33'(root);
      end
    end
    return best;
  endfunction

  function automatic int span(input int h);
    return $signed($urandom_range(0, 6 * h)) - 3 * h;
  endfunction

  // Mostly boxes of modest size with segments around them, some raw noise
  function automatic sbfi_pkg::in_t random_segment();
    sbfi_pkg::in_t x;
    int c[3], h[3], lo[3], hi[3], s[3], e[3], t;
    if ($urandom_range(0, 9) == 0) begin
      x = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return x;
    end
    for (int k = 0; k < 3; k++) begin
      c[k] = $signed($urandom_range(0, 20 * ONE)) - 10 * ONE;
      h[k] = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 4 * ONE);
      lo[k] = c[k] - h[k];
      hi[k] = c[k] + h[k];
      if ($urandom_range(0, 19) == 0) begin
        t = lo[k]; lo[k] = hi[k]; hi[k] = t;
      end
      s[k] = c[k] + span(h[k] + 1);
      e[k] = c[k] + span(h[k] + 1);
      case ($urandom_range(0, 11))
        0: e[k] = s[k] + $signed($urandom_range(0, 50)) - 25;
        1: s[k] = lo[k];
        2: e[k] = hi[k];
        3: e[k] = s[k];
        default: ;
      endcase
    end
    x.box_min_x = lo[0]; x.box_max_x = hi[0];
    x.box_min_y = lo[1]; x.box_max_y = hi[1];
    x.box_min_z = lo[2]; x.box_max_z = hi[2];
    x.start_x = s[0]; x.start_y = s[1]; x.start_z = s[2];
    x.end_x = e[0]; x.end_y = e[1]; x.end_z = e[2];
    return x;
  endfunction

  function automatic void add_row(input sbfi_pkg::in_t x, input bit typed, input hit_t want);
    row_t r;
    r.seg = x;
    r.typed = typed;
    r.want = want;
    rows.push_back(r);
  endfunction

  // Present one item, with bursts and gaps on the sending side
  task automatic offer_item(input row_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) @(negedge clk) in_ch.valid <= 1'b0;
      burst_left = $urandom_range(1, 30);
    end
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.box_min_x <= r.seg.box_min_x;
    in_ch.box_max_x <= r.seg.box_max_x;
    in_ch.box_min_y <= r.seg.box_min_y;
    in_ch.box_max_y <= r.seg.box_max_y;
    in_ch.box_min_z <= r.seg.box_min_z;
    in_ch.box_max_z <= r.seg.box_max_z;
    in_ch.start_x   <= r.seg.start_x;
    in_ch.start_y   <= r.seg.start_y;
    in_ch.start_z   <= r.seg.start_z;
    in_ch.end_x     <= r.seg.end_x;
    in_ch.end_y     <= r.seg.end_y;
    in_ch.end_z     <= r.seg.end_z;
    row_typed       <= r.typed;
    row_want        <= r.want;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
  endtask

  // Predict on input accept, compare on result accept
  always @(posedge clk) begin
    sbfi_pkg::in_t seg;
    hit_t got;
    hit_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        seg = {in_ch.box_min_x, in_ch.box_max_x, in_ch.box_min_y, in_ch.box_max_y,
               in_ch.box_min_z, in_ch.box_max_z, in_ch.start_x, in_ch.start_y,
               in_ch.start_z, in_ch.end_x, in_ch.end_y, in_ch.end_z};
        pending_hits.push_back(row_typed ? row_want : intercept_predict(seg));
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.hit, sbfi_pkg::face_t'(out_ch.face), out_ch.point_x, out_ch.point_y,
               out_ch.point_z, out_ch.distance};
        results_seen++;
        if (pending_hits.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %p", $time, got);
        end else begin
          want = pending_hits.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
          end
        end
      end
    end
  end

  // Receiver stalls on a shifting pattern, with one long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!held && results_seen >= HOLD_AT) begin
      held <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      phase <= phase + 8'd1;
      if (phase[5:0] == 6'd0)
        stall_pat <= ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
      out_ch.ready <= stall_pat[phase[2:0]];
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    hit_t none;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    {in_ch.box_min_x, in_ch.box_max_x, in_ch.box_min_y, in_ch.box_max_y} = '0;
    {in_ch.box_min_z, in_ch.box_max_z, in_ch.start_x, in_ch.start_y} = '0;
    {in_ch.start_z, in_ch.end_x, in_ch.end_y, in_ch.end_z} = '0;
    row_typed = 1'b0; row_want = '0; burst_left = 0;
    none = '0;

    // Directed rows
    add_row('{0, ONE, 0, ONE, 0, ONE, HALF, HALF, HALF, HALF, HALF, HALF}, 1, none);
    add_row('{0, ONE, 0, ONE, 0, ONE, -ONE, HALF, HALF, 2 * ONE, HALF, HALF}, 1,
            '{1'b1, sbfi_pkg::FACE_NEG_X, 0, HALF, HALF, 33'h10000});
    add_row('{0, ONE, 0, ONE, 0, ONE, 2 * ONE, HALF, HALF, -ONE, HALF, HALF}, 1,
            '{1'b1, sbfi_pkg::FACE_POS_X, ONE, HALF, HALF, 33'h10000});
    add_row('{0, ONE, 0, ONE, 0, ONE, HALF, HALF, -ONE, HALF, HALF, 2 * ONE}, 1,
            '{1'b1, sbfi_pkg::FACE_NEG_Z, HALF, HALF, 0, 33'h10000});
    add_row('{0, ONE, 0, ONE, 0, ONE, HALF, HALF, 2 * ONE, HALF, HALF, -ONE}, 1,
            '{1'b1, sbfi_pkg::FACE_POS_Z, HALF, HALF, ONE, 33'h10000});
    add_row('{0, ONE, 0, ONE, 0, ONE, HALF, 2 * ONE, HALF, HALF, -ONE, HALF}, 0, none);
    // just below and just above the parallel threshold
    add_row('{0, ONE, 0, ONE, 0, ONE, HALF, -10, HALF, HALF, 10, HALF}, 1, none);
    add_row('{0, ONE, 0, ONE, 0, ONE, HALF, -10, HALF, HALF, 11, HALF}, 1,
            '{1'b1, sbfi_pkg::FACE_NEG_Y, HALF, 0, HALF, 33'd10});
    // full-range extremes
    add_row('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 0, none);
    add_row('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 0, none);
    add_row('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 0, none);
    add_row('{-1, -1, -1, -1, -1, -1, 0, 0, 0, -1, -1, -1}, 0, none);
    add_row('{-1, 0, -1, 0, -1, 0, -1, -1, -1, 0, 0, 0}, 0, none);
    // corner tie: earlier plane wins
    add_row('{0, ONE, 0, ONE, 0, ONE, -ONE, -ONE, HALF, ONE, ONE, HALF}, 0, none);
    add_row('{0, ONE, 0, ONE, 0, ONE, -ONE, -ONE, -ONE, 2 * ONE, 2 * ONE, 2 * ONE}, 0, none);
    // inverted box
    add_row('{ONE, 0, 0, ONE, 0, ONE, -ONE, HALF, HALF, 2 * ONE, HALF, HALF}, 0, none);
    add_row('{0, ONE, ONE, 0, ONE, 0, -ONE, 3, 7, 2 * ONE, 5, 1}, 0, none);
    // segment ending on a face, starting inside, passing beside, odd rounding
    add_row('{0, ONE, 0, ONE, 0, ONE, -ONE, HALF, HALF, 0, HALF, HALF}, 0, none);
    add_row('{0, ONE, 0, ONE, 0, ONE, HALF, HALF, HALF, 3 * ONE, 2 * ONE, 7}, 0, none);
    add_row('{0, ONE, 0, ONE, 0, ONE, -ONE, 2 * ONE, HALF, 2 * ONE, 2 * ONE, HALF}, 0, none);
    add_row('{0, ONE, 0, ONE, 0, ONE, -3, 1, 2, 4, 6, -5}, 0, none);
    add_row('{-ONE, ONE, -ONE, ONE, -ONE, ONE, -7 * ONE, 5, -3, 7 * ONE, -2, 9}, 0, none);
    add_row('{0, ONE, 0, ONE, 0, ONE, 0, 0, 0, ONE, ONE, ONE}, 0, none);

    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (rows[i]) offer_item(rows[i]);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      row_t r;
      r.seg = random_segment();
      r.typed = 1'b0;
      r.want = none;
      offer_item(r);
    end
    @(negedge clk) in_ch.valid <= 1'b0;

    // Drain
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
